// ===== src/ranged_thermistor_to_temperature_core_assert.svh =====
// Assertion macros for the thermistor converter core.
// Included by the top level; depends on nothing else.
`ifndef RANGED_THERMISTOR_TO_TEMPERATURE_CORE_ASSERT_SVH
`define RANGED_THERMISTOR_TO_TEMPERATURE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RTT_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define RTT_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define RTT_ASSERT_IMP(label, clk, rst_n, a, b)
`define RTT_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== src/rtt_pkg.sv =====
// Types, constants and beta tables for the thermistor converter.
// No dependencies.
`default_nettype none
package rtt_pkg;
    localparam int RATIO_BITS_DEF = 16;
    localparam int MANT_BITS      = 32;
    localparam int LOG_BITS       = 29;
    localparam int PROD_BITS      = 60;
    localparam int DEN_BITS       = 31;
    localparam int DIVD_BITS      = 44;
    localparam int CNT_BITS       = 6;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic signed [15:0] TEMP_MIN = -16'sd5000;
    localparam logic signed [15:0] TEMP_MAX = 16'sd20000;
    localparam logic [16:0] KELVIN_H = 17'd27315;
    localparam logic [DIVD_BITS-1:0] Q_HIGH = 44'd47315;
    localparam logic [DIVD_BITS-1:0] Q_LOW  = 44'd22315;

    localparam logic [2:0] REG_SHORT_LIMIT = 3'd0;
    localparam logic [2:0] REG_OPEN_LIMIT  = 3'd1;
    localparam logic [2:0] REG_LOW_WARM    = 3'd2;
    localparam logic [2:0] REG_LOW_HOT     = 3'd3;
    localparam logic [2:0] REG_HIGH_WARM   = 3'd4;
    localparam logic [2:0] REG_HIGH_HOT    = 3'd5;
    localparam logic [2:0] REG_SWITCH_TEMP = 3'd6;

    localparam longint C_4250 = (longint'(4250) * 100 * (longint'(1) << 24) + 14907) / 29815;
    localparam longint C_4311 = (longint'(4311) * 100 * (longint'(1) << 24) + 14907) / 29815;
    localparam longint C_4334 = (longint'(4334) * 100 * (longint'(1) << 24) + 14907) / 29815;
    localparam longint N_4250 = longint'(4250) * 100 * (longint'(1) << 24);
    localparam longint N_4311 = longint'(4311) * 100 * (longint'(1) << 24);
    localparam longint N_4334 = longint'(4334) * 100 * (longint'(1) << 24);

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SHORT = 2'd1,
        STATUS_OPEN  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BETA_4250,
        BETA_4311,
        BETA_4334
    } beta_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQR,
        ST_MUL,
        ST_DEN,
        ST_DIV,
        ST_OUT
    } st_t;

    // B / 298.15 in Q24.
    function automatic logic [27:0] beta_c(input beta_t b);
        logic [27:0] r;
        unique case (b)
            BETA_4250: r = C_4250[27:0];
            BETA_4311: r = C_4311[27:0];
            default:   r = C_4334[27:0];
        endcase
        return r;
    endfunction

    // 100 * B in Q24, numerator of the kelvin quotient.
    function automatic logic [DIVD_BITS-1:0] beta_num(input beta_t b);
        logic [DIVD_BITS-1:0] r;
        unique case (b)
            BETA_4250: r = N_4250[DIVD_BITS-1:0];
            BETA_4311: r = N_4311[DIVD_BITS-1:0];
            default:   r = N_4334[DIVD_BITS-1:0];
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/rtt_if.sv =====
// Sample and result channels of the thermistor converter.
// Depends on nothing else.
`default_nettype none
interface rtt_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] voltage_ratio;
    modport source (output valid, output voltage_ratio, input ready);
    modport sink (input valid, input voltage_ratio, output ready);
endinterface

interface rtt_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature;
    logic [1:0]         sensor_status;
    logic               high_range;
    modport source (output valid, output temperature, output sensor_status,
                    output high_range, input ready);
    modport sink (input valid, input temperature, input sensor_status,
                  input high_range, output ready);
endinterface
`default_nettype wire

// ===== src/ranged_thermistor_to_temperature_core.sv =====
// Thermistor ratio to temperature converter, top level.
// Depends on rtt_pkg, rtt_if.sv and the assertion macro header.
//
// Usage: one ratio item enters on the sample channel when valid and ready
// are high; exactly one result item leaves on the result channel for it.
// Configuration registers sit on the APB port at byte addresses 4*i.
// Sample ready is high only while the converter is idle, so one item is
// worked on at a time. A shorted, open or zero ratio item goes straight
// to the output state, which loads it into the result register, and the
// converter then returns to idle for the next item. A good item runs two
// base-2 logarithms on one shared unit (a normalizing shift and then a
// squaring step per fractional bit each), a bit-serial multiply by ln 2,
// a denominator step and, for a positive denominator, a restoring divide
// before the output state loads the result register.
// The result register lets the next item enter while a result waits.
// When the receiver stalls, the finished item is held in the work state
// until the result register frees up.
// Reset returns to low range, clears the stored temperature and loads
// the register defaults.
`default_nettype none
`include "ranged_thermistor_to_temperature_core_assert.svh"
module ranged_thermistor_to_temperature_core
    import rtt_pkg::*;
#(
    parameter int RATIO_BITS = RATIO_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rtt_sample_if.sink       sample,
    rtt_result_if.source     result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [15:0] short_limit_reg, open_limit_reg;
    logic [15:0] low_warm_reg, low_hot_reg, high_warm_reg, high_hot_reg;
    logic signed [15:0] switch_temp_reg;

    st_t state_reg, state_next;
    logic                   sel_b_reg;
    logic [RATIO_BITS-1:0]  v_reg;
    status_t                status_reg;
    beta_t                  beta_reg;
    logic                   mode_reg;
    logic signed [15:0]     last_temp_reg, calc_temp_reg;
    logic [MANT_BITS-1:0]   m_reg;
    logic [4:0]             ip_reg;
    logic [LOG_BITS-1:0]    res_reg, la_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic                   neg_reg;
    logic [PROD_BITS-1:0]   p_reg;
    logic [29:0]            den_reg, rem_reg;
    logic [DIVD_BITS-1:0]   q_reg;
    logic                   out_valid_reg, out_high_reg;
    logic signed [15:0]     out_temp_reg;
    logic [1:0]             out_status_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        accept_in, out_load;
    logic [31:0] in_ext, v_in32, v32, w32, xa, xb;
    logic [RATIO_BITS-1:0] v_in;
    status_t     status_in;
    beta_t       beta_in;
    logic [15:0] warm_k, hot_k;
    logic [63:0] sq_prod;
    logic [32:0] sq;
    logic [MANT_BITS-1:0] m_sq;
    logic [LOG_BITS-1:0]  res_fin, diff;
    logic        neg_now;
    logic [30:0] mul_sum;
    logic [PROD_BITS-1:0] p_step;
    logic signed [DEN_BITS-1:0] ln_s, den_s;
    logic [DIVD_BITS-1:0] dividend, q_fin;
    logic [30:0] r2;
    logic        ge;
    logic [29:0] rem_step;
    logic [16:0] t_sub;
    logic signed [15:0] temp_fin, new_temp;
    logic        new_mode;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_SHORT_LIMIT: prdata = {16'd0, short_limit_reg};
            REG_OPEN_LIMIT:  prdata = {16'd0, open_limit_reg};
            REG_LOW_WARM:    prdata = {16'd0, low_warm_reg};
            REG_LOW_HOT:     prdata = {16'd0, low_hot_reg};
            REG_HIGH_WARM:   prdata = {16'd0, high_warm_reg};
            REG_HIGH_HOT:    prdata = {16'd0, high_hot_reg};
            REG_SWITCH_TEMP: prdata = {16'd0, switch_temp_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_limit_reg <= 16'd6554;
            open_limit_reg  <= 16'd62259;
            low_warm_reg    <= 16'd34424;
            low_hot_reg     <= 16'd14955;
            high_warm_reg   <= 16'd50364;
            high_hot_reg    <= 16'd30808;
            switch_temp_reg <= 16'sd5400;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SHORT_LIMIT: short_limit_reg <= pwdata[15:0];
                REG_OPEN_LIMIT:  open_limit_reg  <= pwdata[15:0];
                REG_LOW_WARM:    low_warm_reg    <= pwdata[15:0];
                REG_LOW_HOT:     low_hot_reg     <= pwdata[15:0];
                REG_HIGH_WARM:   high_warm_reg   <= pwdata[15:0];
                REG_HIGH_HOT:    high_hot_reg    <= pwdata[15:0];
                REG_SWITCH_TEMP: switch_temp_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Input classification.
    assign in_ext    = {16'd0, sample.voltage_ratio};
    assign v_in      = in_ext[RATIO_BITS-1:0];
    assign v_in32    = 32'(v_in);
    assign accept_in = sample.valid && sample.ready;

    always_comb
    begin
        warm_k = mode_reg ? high_warm_reg : low_warm_reg;
        hot_k  = mode_reg ? high_hot_reg : low_hot_reg;
        priority if (v_in32 < 32'(short_limit_reg)) status_in = STATUS_SHORT;
        else if (v_in32 > 32'(open_limit_reg))      status_in = STATUS_OPEN;
        else                                         status_in = STATUS_OK;
        priority if (v_in32 > 32'(warm_k)) beta_in = BETA_4250;
        else if (v_in32 > 32'(hot_k))      beta_in = BETA_4311;
        else                                beta_in = BETA_4334;
    end

    // Logarithm operands: series resistor times ratio, and 100 times the rest.
    assign xa  = mode_reg ? ((v_in32 << 3) + (v_in32 << 1))
                          : ((v_in32 << 5) - (v_in32 << 1));
    assign v32 = 32'(v_reg);
    assign w32 = (32'd1 << RATIO_BITS) - v32;
    assign xb  = (w32 << 6) + (w32 << 5) + (w32 << 2);

    // One squaring step of the fractional log bits.
    assign sq_prod = 64'(m_reg) * 64'(m_reg);
    assign sq      = sq_prod[63:31];
    assign m_sq    = sq[32] ? sq[32:1] : sq[31:0];
    assign res_fin = res_reg | (sq[32] ? (LOG_BITS'(1) << cnt_reg[4:0]) : '0);
    assign neg_now = la_reg < res_fin;
    assign diff    = neg_now ? (res_fin - la_reg) : (la_reg - res_fin);

    // Shift-add multiply by ln 2, one multiplier bit per cycle.
    assign mul_sum = p_reg[59:29] + (p_reg[0] ? 31'(LN2_Q30) : 31'd0);
    assign p_step  = {1'b0, mul_sum, p_reg[28:1]};

    assign ln_s     = neg_reg ? -$signed({2'b00, p_reg[58:30]})
                              : $signed({2'b00, p_reg[58:30]});
    assign den_s    = ln_s + $signed({3'b000, beta_c(beta_reg)});
    assign dividend = beta_num(beta_reg) + DIVD_BITS'(den_s[29:1]);

    // Restoring divide, one quotient bit per cycle.
    assign r2       = {rem_reg, q_reg[DIVD_BITS-1]};
    assign ge       = r2 >= {1'b0, den_reg};
    assign rem_step = ge ? 30'(r2 - {1'b0, den_reg}) : r2[29:0];
    assign q_fin    = {q_reg[DIVD_BITS-2:0], ge};
    assign t_sub    = {1'b0, q_fin[15:0]} - KELVIN_H;

    always_comb
    begin
        priority if (q_fin > Q_HIGH) temp_fin = TEMP_MAX;
        else if (q_fin < Q_LOW)      temp_fin = TEMP_MIN;
        else                         temp_fin = t_sub[15:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (status_in != STATUS_OK || v_in == '0) state_next = ST_OUT;
                    else                                      state_next = ST_NORM;
                end
            end
            ST_NORM: if (m_reg[MANT_BITS-1]) state_next = ST_SQR;
            ST_SQR:
            begin
                if (cnt_reg == '0) state_next = sel_b_reg ? ST_MUL : ST_NORM;
            end
            ST_MUL: if (cnt_reg == '0) state_next = ST_DEN;
            ST_DEN: state_next = (den_s > 0) ? ST_DIV : ST_OUT;
            ST_DIV: if (cnt_reg == '0) state_next = ST_OUT;
            ST_OUT: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        sample.ready = (state_reg == ST_IDLE);
        out_load     = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);
        new_temp     = (status_reg == STATUS_OK) ? calc_temp_reg : last_temp_reg;
        new_mode     = (status_reg == STATUS_OK) ? (calc_temp_reg > switch_temp_reg)
                                                 : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                v_reg         <= v_in;
                status_reg    <= status_in;
                beta_reg      <= beta_in;
                calc_temp_reg <= TEMP_MIN;
                sel_b_reg     <= 1'b0;
                m_reg         <= xa;
                ip_reg        <= 5'd31;
            end
            ST_NORM:
            begin
                if (m_reg[MANT_BITS-1])
                begin
                    res_reg <= {ip_reg, 24'd0};
                    cnt_reg <= CNT_BITS'(23);
                end
                else
                begin
                    m_reg  <= m_reg << 1;
                    ip_reg <= ip_reg - 5'd1;
                end
            end
            ST_SQR:
            begin
                res_reg <= res_fin;
                if (cnt_reg == '0)
                begin
                    if (!sel_b_reg)
                    begin
                        la_reg    <= res_fin;
                        sel_b_reg <= 1'b1;
                        m_reg     <= xb;
                        ip_reg    <= 5'd31;
                    end
                    else
                    begin
                        neg_reg <= neg_now;
                        p_reg   <= {31'd0, diff};
                        cnt_reg <= CNT_BITS'(28);
                    end
                end
                else
                begin
                    m_reg   <= m_sq;
                    cnt_reg <= cnt_reg - CNT_BITS'(1);
                end
            end
            ST_MUL:
            begin
                p_reg   <= p_step;
                cnt_reg <= cnt_reg - CNT_BITS'(1);
            end
            ST_DEN:
            begin
                // A zero denominator reads as infinitely hot, a negative one as cold.
                calc_temp_reg <= (den_s == 0) ? TEMP_MAX : TEMP_MIN;
                den_reg       <= den_s[29:0];
                q_reg         <= dividend;
                rem_reg       <= '0;
                cnt_reg       <= CNT_BITS'(43);
            end
            ST_DIV:
            begin
                q_reg   <= q_fin;
                rem_reg <= rem_step;
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0) calc_temp_reg <= temp_fin;
            end
            ST_OUT: ;
            default: ;
        endcase
        if (out_load)
        begin
            out_temp_reg   <= new_temp;
            out_status_reg <= status_reg;
            out_high_reg   <= new_mode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            last_temp_reg <= 16'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                mode_reg      <= new_mode;
                last_temp_reg <= new_temp;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.temperature   = out_temp_reg;
    assign result.sensor_status = out_status_reg;
    assign result.high_range    = out_high_reg;

    `RTT_ASSERT_NXT(a_accept_busy, clk, rst_n, accept_in, state_reg != ST_IDLE)
    `RTT_ASSERT_IMP(a_fault_repeats, clk, rst_n,
                    out_valid_reg && out_status_reg != STATUS_OK,
                    out_temp_reg == last_temp_reg)
    `RTT_ASSERT_IMP(a_norm_nonzero, clk, rst_n, state_reg == ST_NORM, m_reg != '0)
    `RTT_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_reg == ST_DIV, den_reg != '0)
endmodule
`default_nettype wire
